### rtl/core/etlp_pkg.sv
// Shared types, constants and byte classifier for the tag-map line parser.
package etlp_pkg;

    // Defaults for the top-level parameters
    localparam int FILE_BYTES_DEF  = 65536;
    localparam int QUEUE_DEPTH_DEF = 4;

    // max_tags value after reset
    localparam logic [15:0] MAX_TAGS_RESET = 16'hFFFF;

    // Character constants
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;

    // Decimal radix
    localparam logic [3:0] RADIX = 4'd10;

    // Byte classes seen by the parser
    typedef enum logic [2:0] {
        CL_NEWLINE,
        CL_HASH,
        CL_DIGIT,
        CL_BLANK,
        CL_WORD,    // letter or underscore
        CL_OTHER
    } char_class_t;

    // Classified word passed from front to back
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } byte_word_t;

    // Line parse phase
    typedef enum logic [2:0] {
        PH_LINE,
        PH_COMMENT,
        PH_NUMBER,
        PH_SEP,
        PH_NAME,
        PH_TRAIL
    } phase_t;

    // Result status codes
    typedef enum logic [2:0] {
        STS_ENTRY     = 3'd0,
        STS_END_OK    = 3'd1,
        STS_BAD_START = 3'd2,
        STS_MISSING   = 3'd3,
        STS_BAD_CHAR  = 3'd4,
        STS_TOO_MANY  = 3'd5,
        STS_NO_EOL    = 3'd6
    } status_t;

    // Map one byte to its class
    function automatic char_class_t classify(input logic [7:0] b);
        char_class_t c;
        if (b == CH_NEWLINE) begin
            c = CL_NEWLINE;
        end else if (b == CH_HASH) begin
            c = CL_HASH;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            c = CL_DIGIT;
        end else if (b == CH_SPACE || b == CH_CR || b == CH_TAB) begin
            c = CL_BLANK;
        end else if ((b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z) ||
                     b == CH_UNDER) begin
            c = CL_WORD;
        end else begin
            c = CL_OTHER;
        end
        return c;
    endfunction

endpackage

### rtl/core/event_tag_line_parser_core.sv
// A byte passes the front register, the queue and the result register on its way out.
// Throughput: one byte per cycle unless stalled; the engine updates line state per byte.
// Stalls on the result side back up through a QUEUE_DEPTH-word queue and the front register.
// Reset (aresetn low, synchronous): parse state to line start, line 1, counters cleared,
// queue and result slot emptied, max_tags set to 65535.
// Results with end_of_file set also return the parse state to its reset value.
module event_tag_line_parser_core #(
    parameter int FILE_BYTES  = etlp_pkg::FILE_BYTES_DEF,
    parameter int QUEUE_DEPTH = etlp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_tag_number,
    output logic [15:0] m_name_offset,
    output logic [15:0] m_name_length,
    output logic [15:0] m_line_number,
    output logic [15:0] m_tags_seen,
    output logic        m_end_of_file
);

    logic                 fw_valid;
    logic                 fw_ready;
    etlp_pkg::byte_word_t fw_data;
    logic                 bw_valid;
    logic                 bw_ready;
    etlp_pkg::byte_word_t bw_data;

    // Classify bytes
    etlp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_byte_in   (s_byte_in),
        .s_last_byte (s_last_byte),
        .word_valid  (fw_valid),
        .word_ready  (fw_ready),
        .word_data   (fw_data)
    );

    // Decoupling queue
    etlp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fw_valid),
        .wr_ready (fw_ready),
        .wr_data  (fw_data),
        .rd_valid (bw_valid),
        .rd_ready (bw_ready),
        .rd_data  (bw_data)
    );

    // Parse engine
    etlp_back #(
        .FILE_BYTES (FILE_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .word_valid    (bw_valid),
        .word_ready    (bw_ready),
        .word_data     (bw_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_tag_number  (m_tag_number),
        .m_name_offset (m_name_offset),
        .m_name_length (m_name_length),
        .m_line_number (m_line_number),
        .m_tags_seen   (m_tags_seen),
        .m_end_of_file (m_end_of_file)
    );

endmodule

### rtl/core/etlp_front.sv
// Front end: accepts input bytes, classifies them and registers the word.
module etlp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_byte_in,
    input  logic                 s_last_byte,
    output logic                 word_valid,
    input  logic                 word_ready,
    output etlp_pkg::byte_word_t word_data
);

    logic                 vld_reg;
    logic                 vld_next;
    etlp_pkg::byte_word_t word_reg;
    etlp_pkg::byte_word_t word_next;

    // Take a byte when the stage is empty or drains this cycle
    assign s_ready = !vld_reg || word_ready;

    // Classify the incoming byte
    always_comb begin
        word_next.cls   = etlp_pkg::classify(s_byte_in);
        word_next.digit = s_byte_in[3:0];
        word_next.last  = s_last_byte;
    end

    always_comb begin
        vld_next = vld_reg;
        if (s_ready) begin
            vld_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= word_next;
        end
    end

    assign word_valid = vld_reg;
    assign word_data  = word_reg;

endmodule

### rtl/core/etlp_queue.sv
// Short word queue that decouples the front end from the parse engine.
module etlp_queue #(
    parameter int QUEUE_DEPTH = etlp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  etlp_pkg::byte_word_t wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output etlp_pkg::byte_word_t rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    etlp_pkg::byte_word_t mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/etlp_back.sv
// Parse engine: runs the line state machine and holds the result register.
module etlp_back #(
    parameter int FILE_BYTES = etlp_pkg::FILE_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 word_valid,
    output logic                 word_ready,
    input  etlp_pkg::byte_word_t word_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [31:0]          m_tag_number,
    output logic [15:0]          m_name_offset,
    output logic [15:0]          m_name_length,
    output logic [15:0]          m_line_number,
    output logic [15:0]          m_tags_seen,
    output logic                 m_end_of_file
);

    localparam int POS_W = $clog2(FILE_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FILE_BYTES - 1);

    // Parse state
    etlp_pkg::phase_t phase_reg;
    etlp_pkg::phase_t phase_next;
    logic [15:0]      line_reg;
    logic [15:0]      line_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [31:0]      num_reg;
    logic [31:0]      num_next;
    logic [POS_W-1:0] nstart_reg;
    logic [POS_W-1:0] nstart_next;
    logic [15:0]      nlen_reg;
    logic [15:0]      nlen_next;
    logic [15:0]      count_reg;
    logic [15:0]      count_next;
    logic             err_reg;
    logic             err_next;
    logic [15:0]      max_tags_reg;

    // Result register
    logic                 out_vld_reg;
    logic                 out_vld_next;
    etlp_pkg::status_t    status_reg;
    logic [31:0]          tag_reg;
    logic [15:0]          off_reg;
    logic [15:0]          len_reg;
    logic [15:0]          rline_reg;
    logic [15:0]          seen_reg;
    logic                 eof_reg;

    // Result being formed this cycle
    logic                 res_fire;
    etlp_pkg::status_t    res_status;
    logic [31:0]          res_tag;
    logic [15:0]          res_off;
    logic [15:0]          res_len;
    logic [15:0]          res_line;
    logic [15:0]          res_seen;

    logic        out_free;
    logic        pop;
    logic        take;
    logic        is_nl;
    logic        line_bump;
    logic [31:0] num_step;

    assign out_free   = !out_vld_reg || m_ready;
    assign word_ready = out_free;
    assign pop        = word_valid && out_free;
    assign take       = pop && !err_reg;
    assign is_nl      = (word_data.cls == etlp_pkg::CL_NEWLINE);

    // accum * 10 + digit as shift-add
    assign num_step = {num_reg[28:0], 3'b000} + {num_reg[30:0], 1'b0} +
                      32'(word_data.digit);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            unique case (phase_reg)
                etlp_pkg::PH_LINE: begin
                    if (word_data.cls == etlp_pkg::CL_HASH) begin
                        phase_next = etlp_pkg::PH_COMMENT;
                    end else if (word_data.cls == etlp_pkg::CL_DIGIT &&
                                 count_reg < max_tags_reg) begin
                        phase_next = etlp_pkg::PH_NUMBER;
                    end
                end
                etlp_pkg::PH_COMMENT: begin
                    if (is_nl) begin
                        phase_next = etlp_pkg::PH_LINE;
                    end
                end
                etlp_pkg::PH_NUMBER: begin
                    if (word_data.cls != etlp_pkg::CL_DIGIT && !is_nl) begin
                        phase_next = etlp_pkg::PH_SEP;
                    end
                end
                etlp_pkg::PH_SEP: begin
                    if (!is_nl && word_data.cls != etlp_pkg::CL_BLANK) begin
                        phase_next = etlp_pkg::PH_NAME;
                    end
                end
                etlp_pkg::PH_NAME: begin
                    if (is_nl) begin
                        phase_next = etlp_pkg::PH_LINE;
                    end else if (word_data.cls == etlp_pkg::CL_BLANK) begin
                        phase_next = etlp_pkg::PH_TRAIL;
                    end
                end
                etlp_pkg::PH_TRAIL: begin
                    if (is_nl) begin
                        phase_next = etlp_pkg::PH_LINE;
                    end
                end
                default: begin
                    phase_next = etlp_pkg::PH_LINE;
                end
            endcase
        end
        // End of file restarts the parse
        if (pop && word_data.last) begin
            phase_next = etlp_pkg::PH_LINE;
        end
    end

    // Datapath and result forming
    always_comb begin
        line_next   = line_reg;
        pos_next    = pos_reg;
        num_next    = num_reg;
        nstart_next = nstart_reg;
        nlen_next   = nlen_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        line_bump   = 1'b0;
        res_fire    = 1'b0;
        res_status  = etlp_pkg::STS_ENTRY;
        res_tag     = '0;
        res_off     = '0;
        res_len     = '0;
        res_line    = line_reg;
        res_seen    = count_reg;

        if (take) begin
            unique case (phase_reg)
                etlp_pkg::PH_LINE: begin
                    if (is_nl) begin
                        line_bump = 1'b1;
                    end else if (word_data.cls == etlp_pkg::CL_DIGIT) begin
                        if (count_reg >= max_tags_reg) begin
                            res_fire   = 1'b1;
                            res_status = etlp_pkg::STS_TOO_MANY;
                        end else begin
                            num_next = 32'(word_data.digit);
                        end
                    end else if (word_data.cls != etlp_pkg::CL_HASH &&
                                 word_data.cls != etlp_pkg::CL_BLANK) begin
                        res_fire   = 1'b1;
                        res_status = etlp_pkg::STS_BAD_START;
                    end
                end
                etlp_pkg::PH_COMMENT: begin
                    if (is_nl) begin
                        line_bump = 1'b1;
                    end
                end
                etlp_pkg::PH_NUMBER: begin
                    if (word_data.cls == etlp_pkg::CL_DIGIT) begin
                        num_next = num_step;
                    end else if (is_nl) begin
                        res_fire   = 1'b1;
                        res_status = etlp_pkg::STS_MISSING;
                    end
                end
                etlp_pkg::PH_SEP: begin
                    if (is_nl) begin
                        res_fire   = 1'b1;
                        res_status = etlp_pkg::STS_MISSING;
                    end else if (word_data.cls != etlp_pkg::CL_BLANK) begin
                        nstart_next = pos_reg;
                        nlen_next   = 16'd1;
                    end
                end
                etlp_pkg::PH_NAME, etlp_pkg::PH_TRAIL: begin
                    if (is_nl) begin
                        // Tag entry complete
                        res_fire   = 1'b1;
                        res_status = etlp_pkg::STS_ENTRY;
                        res_tag    = num_reg;
                        res_off    = 16'(nstart_reg);
                        res_len    = nlen_reg;
                        count_next = count_reg + 1'b1;
                        res_seen   = count_reg + 1'b1;
                        line_bump  = 1'b1;
                    end else if (phase_reg == etlp_pkg::PH_NAME) begin
                        if (word_data.cls == etlp_pkg::CL_DIGIT ||
                            word_data.cls == etlp_pkg::CL_WORD) begin
                            if (nlen_reg != 16'hFFFF) begin
                                nlen_next = nlen_reg + 1'b1;
                            end
                        end else if (word_data.cls != etlp_pkg::CL_BLANK) begin
                            res_fire   = 1'b1;
                            res_status = etlp_pkg::STS_BAD_CHAR;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (res_fire && res_status != etlp_pkg::STS_ENTRY) begin
                err_next = 1'b1;
            end
        end

        // Saturating line counter
        if (line_bump && line_reg != 16'hFFFF) begin
            line_next = line_reg + 1'b1;
        end

        if (pop) begin
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        end

        // Last byte: end status if no other result and no earlier error, then clear parse state
        if (pop && word_data.last) begin
            if (!res_fire && !err_reg) begin
                res_fire   = 1'b1;
                res_status = is_nl ? etlp_pkg::STS_END_OK : etlp_pkg::STS_NO_EOL;
                res_line   = line_next;
            end
            line_next   = 16'd1;
            pos_next    = '0;
            num_next    = '0;
            nstart_next = '0;
            nlen_next   = '0;
            count_next  = '0;
            err_next    = 1'b0;
        end
    end

    // Output slot
    always_comb begin
        out_vld_next = out_vld_reg;
        if (out_free) begin
            out_vld_next = pop && res_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= etlp_pkg::PH_LINE;
            line_reg     <= 16'd1;
            pos_reg      <= '0;
            num_reg      <= '0;
            nstart_reg   <= '0;
            nlen_reg     <= '0;
            count_reg    <= '0;
            err_reg      <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            line_reg     <= line_next;
            pos_reg      <= pos_next;
            num_reg      <= num_next;
            nstart_reg   <= nstart_next;
            nlen_reg     <= nlen_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Tag limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_tags_reg <= etlp_pkg::MAX_TAGS_RESET;
        end else if (cfg_wr_en) begin
            max_tags_reg <= cfg_wr_data;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop && res_fire) begin
            status_reg <= res_status;
            tag_reg    <= res_tag;
            off_reg    <= res_off;
            len_reg    <= res_len;
            rline_reg  <= res_line;
            seen_reg   <= res_seen;
            eof_reg    <= word_data.last;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_status      = status_reg;
    assign m_tag_number  = tag_reg;
    assign m_name_offset = off_reg;
    assign m_name_length = len_reg;
    assign m_line_number = rline_reg;
    assign m_tags_seen   = seen_reg;
    assign m_end_of_file = eof_reg;

endmodule
